/* hdl/sm3_pkg.sv */
// Shared types, constants and round functions for the SM3 hash engine.
package sm3_pkg;

  typedef struct packed {
    logic [31:0] data_word;
    logic [2:0]  byte_count;
    logic        last_word;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_done;
  } digest_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMPRESS,
    ST_OUT
  } state_t;

  typedef enum logic [2:0] {
    PH_NONE,
    PH_MARK,
    PH_ZERO,
    PH_LO,
    PH_DONE
  } pad_phase_t;

  localparam logic [31:0] TJ_LOW   = 32'h79cc4519;
  localparam logic [31:0] TJ_HIGH  = 32'h7a879d8a;
  localparam logic [31:0] PAD_WORD = 32'h80000000;
  localparam int unsigned NUM_ROUNDS = 64;

  function automatic logic [31:0] iv_word(input logic [2:0] idx);
    logic [31:0] w;
    case (idx)
      3'd0:    w = 32'h7380166f;
      3'd1:    w = 32'h4914b2b9;
      3'd2:    w = 32'h172442d7;
      3'd3:    w = 32'hda8a0600;
      3'd4:    w = 32'ha96f30bc;
      3'd5:    w = 32'h163138aa;
      3'd6:    w = 32'he38dee4d;
      default: w = 32'hb0fb0e4e;
    endcase
    return w;
  endfunction

  // Shift by 32 yields zero, so a rotation by zero is the identity.
  function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
    logic [5:0] m;
    m = 6'd32 - {1'b0, n};
    return (x << n) | (x >> m);
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rol32(x, 5'd9) ^ rol32(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rol32(x, 5'd15) ^ rol32(x, 5'd23);
  endfunction

endpackage

/* hdl/sm3_hash_engine.sv */
// SM3 hash engine: word intake, padding, round sequencer and digest output.
//
// Message words enter on the msg channel (msg_valid / msg_stall / msg), first
// byte in bits 31..24. A word with last_word set closes the message; its
// byte_count (0..4, larger taken as 4) gives the valid leading bytes.
// Every 16 words the engine runs one SM3 compression: 64 rounds, one round
// per cycle, with the message expansion computed alongside from a 16-word
// sliding window. msg_stall is high while padding, compressing or emitting.
// A non-last word that completes a block is followed by one compression.
// The last word is followed by its padding words and by one or two
// compressions, then the eight digest words appear on the digest channel
// (digest_valid / digest_stall / digest), one per cycle when not stalled,
// index 0 first, digest_done on index 7.
// While digest_stall is high the current digest item holds.
// After the eighth word the chaining value, bit length and fill count return
// to their initial values for the next message.
// Reset (rst, synchronous) loads the SM3 initial value and clears the length
// and fill count; msg_stall is low in reset, so the engine is ready as soon as reset drops.
module sm3_hash_engine
  import sm3_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         msg_valid,
  output logic         msg_stall,
  input  msg_item_t    msg,
  output logic         digest_valid,
  input  logic         digest_stall,
  output digest_item_t digest
);

  state_t      state, state_next;
  pad_phase_t  phase, phase_next;
  logic [3:0]  fill;
  logic [63:0] bit_length, bit_length_next;
  logic [5:0]  round;
  logic [2:0]  out_idx;
  logic [31:0] v [8];
  logic [31:0] r [8];
  logic [31:0] win [16];

  logic        push;
  logic [31:0] push_word;
  logic        msg_accept, digest_accept;
  logic [2:0]  cnt;
  logic [31:0] keep, mark;

  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, w_new;
  logic [31:0] r_next [8];

  assign msg_stall     = (state != ST_IDLE);
  assign msg_accept    = msg_valid && !msg_stall;
  assign digest_valid  = (state == ST_OUT);
  assign digest_accept = digest_valid && !digest_stall;

  assign digest.digest_word = v[out_idx];
  assign digest.word_index  = out_idx;
  assign digest.digest_done = (out_idx == 3'd7);

  assign cnt = (msg.byte_count > 3'd4) ? 3'd4 : msg.byte_count;

  always_comb begin
    case (cnt)
      3'd0: begin keep = 32'h00000000; mark = 32'h80000000; end
      3'd1: begin keep = 32'hff000000; mark = 32'h00800000; end
      3'd2: begin keep = 32'hffff0000; mark = 32'h00008000; end
      3'd3: begin keep = 32'hffffff00; mark = 32'h00000080; end
      default: begin keep = 32'hffffffff; mark = 32'h00000000; end
    endcase
  end

  // one round of the compression and one new expanded word
  always_comb begin
    tj  = (round[5:4] == 2'b00) ? TJ_LOW : TJ_HIGH;
    a12 = rol32(r[0], 5'd12);
    ss1 = rol32(a12 + r[4] + rol32(tj, round[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (round[5:4] == 2'b00) begin
      ff = r[0] ^ r[1] ^ r[2];
      gg = r[4] ^ r[5] ^ r[6];
    end else begin
      ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
      gg = (r[4] & r[5]) | (~r[4] & r[6]);
    end
    tt1 = ff + r[3] + ss2 + (win[0] ^ win[4]);
    tt2 = gg + r[7] + ss1 + win[0];
    r_next[0] = tt1;
    r_next[1] = r[0];
    r_next[2] = rol32(r[1], 5'd9);
    r_next[3] = r[2];
    r_next[4] = perm0(tt2);
    r_next[5] = r[4];
    r_next[6] = rol32(r[5], 5'd19);
    r_next[7] = r[6];
    w_new = perm1(win[0] ^ win[7] ^ rol32(win[13], 5'd15))
            ^ rol32(win[3], 5'd7) ^ win[10];
  end

  always_comb begin
    state_next      = state;
    phase_next      = phase;
    bit_length_next = bit_length;
    push            = 1'b0;
    push_word       = '0;
    case (state)
      ST_IDLE: begin
        if (msg_accept) begin
          push = 1'b1;
          if (!msg.last_word) begin
            push_word       = msg.data_word;
            bit_length_next = bit_length + 64'd32;
          end else begin
            bit_length_next = bit_length + {58'd0, cnt, 3'b000};
            push_word       = (msg.data_word & keep) | mark;
            phase_next      = (cnt == 3'd4) ? PH_MARK : PH_ZERO;
          end
          if (fill == 4'd15) begin
            state_next = ST_COMPRESS;
          end else if (msg.last_word) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        push = 1'b1;
        case (phase)
          PH_MARK: begin
            push_word  = PAD_WORD;
            phase_next = PH_ZERO;
          end
          PH_ZERO: begin
            if (fill == 4'd14) begin
              push_word  = bit_length[63:32];
              phase_next = PH_LO;
            end
          end
          PH_LO: begin
            push_word  = bit_length[31:0];
            phase_next = PH_DONE;
          end
          default: push = 1'b0;
        endcase
        if (fill == 4'd15) begin
          state_next = ST_COMPRESS;
        end
      end
      ST_COMPRESS: begin
        if (round == 6'(NUM_ROUNDS - 1)) begin
          if (phase == PH_DONE) begin
            state_next = ST_OUT;
          end else if (phase == PH_NONE) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_PAD;
          end
        end
      end
      ST_OUT: begin
        if (digest_accept && out_idx == 3'd7) begin
          state_next      = ST_IDLE;
          phase_next      = PH_NONE;
          bit_length_next = '0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_NONE;
      fill       <= '0;
      bit_length <= '0;
      round      <= '0;
      out_idx    <= '0;
      for (int i = 0; i < 8; i++) begin
        v[i] <= iv_word(3'(i));
      end
    end else begin
      state      <= state_next;
      phase      <= phase_next;
      bit_length <= bit_length_next;
      if (push) begin
        fill <= fill + 4'd1;
        if (fill == 4'd15) begin
          round <= '0;
        end
      end
      if (state == ST_COMPRESS) begin
        round <= round + 6'd1;
        if (round == 6'(NUM_ROUNDS - 1)) begin
          for (int i = 0; i < 8; i++) begin
            v[i] <= v[i] ^ r_next[i];
          end
        end
      end
      if (digest_accept) begin
        out_idx <= out_idx + 3'd1;
        if (out_idx == 3'd7) begin
          for (int i = 0; i < 8; i++) begin
            v[i] <= iv_word(3'(i));
          end
        end
      end
    end
  end

  // message window and working registers
  always_ff @(posedge clk) begin
    if (push) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= push_word;
      if (fill == 4'd15) begin
        for (int i = 0; i < 8; i++) begin
          r[i] <= v[i];
        end
      end
    end else if (state == ST_COMPRESS) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= w_new;
      for (int i = 0; i < 8; i++) begin
        r[i] <= r_next[i];
      end
    end
  end

  a_out_blocks_in: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> msg_stall)
    else $error("input taken while digest pending");

  a_out_block_empty: assert property (@(posedge clk) disable iff (rst)
    digest_valid |-> (fill == 4'd0 && phase == PH_DONE))
    else $error("digest shown with partial block");

  a_compress_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_COMPRESS && round == 6'(NUM_ROUNDS - 1)) |=> state != ST_COMPRESS)
    else $error("compression ran past last round");

  a_compress_starts: assert property (@(posedge clk) disable iff (rst)
    (state != ST_COMPRESS && state_next == ST_COMPRESS) |-> (push && fill == 4'd15))
    else $error("compression started without a full block");

  a_digest_end: assert property (@(posedge clk) disable iff (rst)
    (digest_accept && out_idx == 3'd7) |=> (state == ST_IDLE && bit_length == 64'd0))
    else $error("engine not back to idle after digest");

endmodule

/* bench/sm3_hash_engine_tb.sv */
// Self-checking testbench for the SM3 hash engine with an SM3 digest predictor.
`timescale 1ns / 1ps

class sm3_digest_scoreboard;
  localparam logic [31:0] TJ_EARLY = 32'h79cc4519;
  localparam logic [31:0] TJ_LATE  = 32'h7a879d8a;
  localparam logic [7:0]  MARK_BYTE = 8'h80;

  logic [31:0] chain [8];
  logic [31:0] blk [16];
  logic [3:0]  fill;
  logic [63:0] msg_bits;
  sm3_pkg::digest_item_t digest_q [$];
  int errors;
  int shown;

  function new();
    errors = 0;
    shown = 0;
    fill = '0;
    restart();
  endfunction

  function void restart();
    chain[0] = 32'h7380166f;
    chain[1] = 32'h4914b2b9;
    chain[2] = 32'h172442d7;
    chain[3] = 32'hda8a0600;
    chain[4] = 32'ha96f30bc;
    chain[5] = 32'h163138aa;
    chain[6] = 32'he38dee4d;
    chain[7] = 32'hb0fb0e4e;
    msg_bits = '0;
    fill = '0;
  endfunction

  function logic [31:0] rotl(logic [31:0] x, int n);
    int s;
    s = n % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function logic [31:0] mix0(logic [31:0] x);
    return x ^ rotl(x, 9) ^ rotl(x, 17);
  endfunction

  function logic [31:0] mix1(logic [31:0] x);
    return x ^ rotl(x, 15) ^ rotl(x, 23);
  endfunction

  function void absorb_block();
    logic [31:0] w [68];
    logic [31:0] r [8];
    logic [31:0] a12, tj, ss1, ss2, ff, gg, tt1, tt2;
    for (int j = 0; j < 16; j++) w[j] = blk[j];
    for (int j = 16; j < 68; j++)
      w[j] = mix1(w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15)) ^ rotl(w[j-13], 7) ^ w[j-6];
    for (int j = 0; j < 8; j++) r[j] = chain[j];
    for (int j = 0; j < 64; j++) begin
      a12 = rotl(r[0], 12);
      tj = (j < 16) ? TJ_EARLY : TJ_LATE;
      ss1 = rotl(a12 + r[4] + rotl(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = r[0] ^ r[1] ^ r[2];
        gg = r[4] ^ r[5] ^ r[6];
      end else begin
        ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
        gg = (r[4] & r[5]) | (~r[4] & r[6]);
      end
      tt1 = ff + r[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + r[7] + ss1 + w[j];
      r[3] = r[2];
      r[2] = rotl(r[1], 9);
      r[1] = r[0];
      r[0] = tt1;
      r[7] = r[6];
      r[6] = rotl(r[5], 19);
      r[5] = r[4];
      r[4] = mix0(tt2);
    end
    for (int j = 0; j < 8; j++) chain[j] ^= r[j];
  endfunction

  function void add_word(logic [31:0] w);
    blk[fill] = w;
    fill = fill + 4'd1;
    if (fill == 4'd0) absorb_block();
  endfunction

  function void note_msg(sm3_pkg::msg_item_t it);
    int nb;
    logic [31:0] keep;
    sm3_pkg::digest_item_t d;
    if (!it.last_word) begin
      msg_bits += 64'd32;
      add_word(it.data_word);
      return;
    end
    nb = (it.byte_count > 3'd4) ? 4 : int'(it.byte_count);
    msg_bits += 64'(8 * nb);
    if (nb == 4) begin
      add_word(it.data_word);
      add_word({MARK_BYTE, 24'h0});
    end else begin
      keep = (nb == 0) ? 32'h0 : (32'hffffffff << (32 - 8 * nb));
      add_word((it.data_word & keep) | ({24'h0, MARK_BYTE} << (24 - 8 * nb)));
    end
    // length field does not fit: close this block with zeros first
    if (fill > 4'd14) begin
      while (fill != 4'd0) add_word('0);
    end
    while (fill < 4'd14) add_word('0);
    add_word(msg_bits[63:32]);
    add_word(msg_bits[31:0]);
    for (int k = 0; k < 8; k++) begin
      d.digest_word = chain[k];
      d.word_index = 3'(k);
      d.digest_done = (k == 7);
      digest_q.push_back(d);
    end
    restart();
  endfunction

  function void check_digest(sm3_pkg::digest_item_t got);
    sm3_pkg::digest_item_t want;
    if (digest_q.size() == 0) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%0t: unexpected digest item word=%h index=%0d done=%0b",
                 $time, got.digest_word, got.word_index, got.digest_done);
      end
      return;
    end
    want = digest_q.pop_front();
    if (got.digest_word !== want.digest_word || got.word_index !== want.word_index ||
        got.digest_done !== want.digest_done) begin
      errors++;
      if (shown < 10) begin
        shown++;
        $display("%0t: digest mismatch exp word=%h index=%0d done=%0b",
                 $time, want.digest_word, want.word_index, want.digest_done);
        $display("    got word=%h index=%0d done=%0b",
                 got.digest_word, got.word_index, got.digest_done);
      end
    end
  endfunction

  function int pending();
    return digest_q.size();
  endfunction

  function int failures();
    return errors + digest_q.size();
  endfunction
endclass

module sm3_hash_engine_tb;
  import sm3_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MSG_ITEMS = 410;
  localparam int HOLD_CYCLES = 400;

  logic         clk = 1'b0;
  logic         rst;
  logic         msg_valid;
  logic         msg_stall;
  msg_item_t    msg;
  logic         digest_valid;
  logic         digest_stall;
  digest_item_t digest;

  sm3_digest_scoreboard sb;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  tx_quiet = 1'b0;

  sm3_hash_engine dut (
    .clk         (clk),
    .rst         (rst),
    .msg_valid   (msg_valid),
    .msg_stall   (msg_stall),
    .msg         (msg),
    .digest_valid(digest_valid),
    .digest_stall(digest_stall),
    .digest      (digest)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && msg_valid && !msg_stall) sb.note_msg(msg);
    if (!rst && digest_valid && !digest_stall) sb.check_digest(digest);
  end

  // digest receiver: random stalls, quiet stretches, one long hold-off
  initial begin
    int n;
    int taken;
    bit rx_quiet;
    taken = 0;
    rx_quiet = 1'b0;
    digest_stall <= 1'b0;
    forever begin
      if (taken % 8 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      if (taken == 40) n = HOLD_CYCLES;
      else n = rx_quiet ? 0 : $urandom_range(0, 12);
      if (n > 0) begin
        digest_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      digest_stall <= 1'b0;
      do @(posedge clk); while (rst || !digest_valid);
      taken++;
    end
  end

  task automatic send_item(input logic [31:0] d, input logic [2:0] c, input logic l);
    int gap;
    msg_item_t it;
    it.data_word = d;
    it.byte_count = c;
    it.last_word = l;
    gap = tx_quiet ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      msg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    msg <= it;
    msg_valid <= 1'b1;
    do @(posedge clk); while (msg_stall);
    items_sent++;
  endtask

  task automatic send_message(input int nwords, input logic [2:0] tail_count);
    for (int i = 0; i < nwords; i++)
      send_item($urandom, 3'($urandom_range(0, 7)), 1'b0);
    send_item($urandom, tail_count, 1'b1);
  endtask

  initial begin
    int n;
    sb = new();
    rst <= 1'b1;
    msg_valid <= 1'b0;
    msg <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty message, every tail byte count, ignored counts, length spill
    send_item(32'h00000000, 3'd0, 1'b1);
    send_item(32'hffffffff, 3'd4, 1'b1);
    send_item(32'hffffffff, 3'd1, 1'b1);
    send_item(32'ha5a5a5a5, 3'd2, 1'b1);
    send_item(32'h12345678, 3'd3, 1'b1);
    send_item(32'hffffffff, 3'd7, 1'b1);
    send_item(32'h00000000, 3'd5, 1'b0);
    send_item(32'hdeadbeef, 3'd6, 1'b1);
    send_message(13, 3'd4);
    send_message(14, 3'd4);

    while (items_sent < MSG_ITEMS) begin
      tx_quiet = ($urandom_range(0, 5) == 0);
      case ($urandom_range(0, 3))
        0:       n = $urandom_range(0, 3);
        1:       n = 16 * $urandom_range(0, 1) + $urandom_range(12, 15);
        default: n = $urandom_range(0, 40);
      endcase
      send_message(n, 3'($urandom_range(0, 7)));
    end
    msg_valid <= 1'b0;

    // let the monitor note the final item before waiting on the digest
    repeat (2) @(posedge clk);
    while (sb.pending() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.failures() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

/* sm3_hash_engine.f */
hdl/sm3_pkg.sv
hdl/sm3_hash_engine.sv
bench/sm3_hash_engine_tb.sv
